FILE: src/stok_pkg.sv
// shared types and constants of the s-expression tokenizer
// depends on nothing; the front end, queue, output stage and top level import it
package stok_pkg;

    localparam int LINE_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TOKEN_LINE_W   = 16;
    localparam int QUEUE_DEPTH    = 4;

    // characters the lexer looks at
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        EV_OPEN  = 3'd0,
        EV_QOPEN = 3'd1,
        EV_CLOSE = 3'd2,
        EV_WBYTE = 3'd3,
        EV_SBYTE = 3'd4,
        EV_WEND  = 3'd5,
        EV_SEND  = 3'd6
    } ev_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_BAR      = 3'd1,
        ERR_NO_CLOSE    = 3'd2,
        ERR_STRAY_CLOSE = 3'd3,
        ERR_EOS_STRING  = 3'd4
    } err_t;

    typedef struct packed {
        ev_t                     ev;
        logic [7:0]              data;
        logic [TOKEN_LINE_W-1:0] line;
        err_t                    err;
    } res_t;

    // events caused by one text byte; r0 always valid, r1 when two is set
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } pkt_t;

endpackage

FILE: src/stok_if.sv
// channel interfaces of the s-expression tokenizer: text bytes in, events out
// depends on nothing
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;

    modport source (output valid, output command, output text_byte, input ready);
    modport sink   (input valid, input command, input text_byte, output ready);
endinterface

interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  out_byte;
    logic [15:0] token_line;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output event_res, output out_byte, output token_line,
                    output error_code, output last, input ready);
    modport sink   (input valid, input event_res, input out_byte, input token_line,
                    input error_code, input last, output ready);
endinterface

FILE: src/stok_front.sv
// lexer front end: accepts text bytes, runs the lexer state, packs events
// depends on stok_pkg and stok_if
module stok_front #(
    parameter int LINE_BITS  = stok_pkg::LINE_BITS_DEF,
    parameter int COUNT_BITS = stok_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    stok_in_if.sink       text,
    output logic          push_valid,
    output stok_pkg::pkt_t push_data,
    input  logic          push_ready
);
    import stok_pkg::*;

    typedef enum logic [9:0] {
        MODE_IDLE     = 10'b00_0000_0001,
        MODE_QUOTE    = 10'b00_0000_0010,
        MODE_WORD     = 10'b00_0000_0100,
        MODE_WORD_ESC = 10'b00_0000_1000,
        MODE_BRACE    = 10'b00_0001_0000,
        MODE_QSTR     = 10'b00_0010_0000,
        MODE_QSTR_ESC = 10'b00_0100_0000,
        MODE_DIGITS   = 10'b00_1000_0000,
        MODE_COUNTED  = 10'b01_0000_0000,
        MODE_CLOSE    = 10'b10_0000_0000
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [LINE_BITS-1:0]  start_reg, start_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic       accept;
    logic [7:0] b;
    logic       pre_emit, idle_emit, do_idle;
    res_t       pre_res, idle_res;
    logic [COUNT_BITS+3:0] times10;
    logic [COUNT_BITS-1:0] digit_count;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT
            || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE
            || c == CH_QUOTE || is_ws(c);
    endfunction

    function automatic logic [TOKEN_LINE_W-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'h0_FFFF) ? {TOKEN_LINE_W{1'b1}} : w[TOKEN_LINE_W-1:0];
    endfunction

    assign b          = text.text_byte;
    assign text.ready = push_ready;
    assign accept     = text.valid && push_ready;

    // count * 10 + digit, saturating
    assign times10 = ({4'b0, count_reg} << 3) + ({4'b0, count_reg} << 1)
                   + {{COUNT_BITS{1'b0}}, b[3:0]};
    assign digit_count = (times10[COUNT_BITS+3:COUNT_BITS] != 4'b0)
                       ? {COUNT_BITS{1'b1}} : times10[COUNT_BITS-1:0];

    always_comb
    begin
        mode_next    = mode_reg;
        line_next    = line_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        pre_emit     = 1'b0;
        do_idle      = 1'b0;
        idle_emit    = 1'b0;
        pre_res.ev   = EV_OPEN;
        pre_res.data = 8'h00;
        pre_res.err  = ERR_NONE;
        pre_res.line = sat_line(start_reg);
        idle_res.ev   = EV_OPEN;
        idle_res.data = 8'h00;
        idle_res.err  = ERR_NONE;
        idle_res.line = sat_line(line_reg);

        if (text.command)
        begin
            // end of stream: close whatever is open, then start over
            unique case (mode_reg)
                MODE_WORD, MODE_WORD_ESC:
                begin
                    pre_emit   = 1'b1;
                    pre_res.ev = EV_WEND;
                end
                MODE_BRACE, MODE_QSTR, MODE_QSTR_ESC, MODE_DIGITS, MODE_COUNTED:
                begin
                    pre_emit    = 1'b1;
                    pre_res.ev  = EV_SEND;
                    pre_res.err = ERR_EOS_STRING;
                end
                MODE_CLOSE:
                begin
                    pre_emit    = 1'b1;
                    pre_res.ev  = EV_SEND;
                    pre_res.err = ERR_NO_CLOSE;
                end
                default:
                begin
                end
            endcase
            mode_next  = MODE_IDLE;
            line_next  = LINE_BITS'(1);
            start_next = LINE_BITS'(1);
            count_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_QUOTE:
                begin
                    if (b == CH_LPAREN)
                    begin
                        pre_emit   = 1'b1;
                        pre_res.ev = EV_QOPEN;
                        mode_next  = MODE_IDLE;
                    end
                    else
                        do_idle = 1'b1;
                end
                MODE_WORD:
                begin
                    if (is_delim(b))
                    begin
                        pre_emit   = 1'b1;
                        pre_res.ev = EV_WEND;
                        do_idle    = 1'b1;
                    end
                    else if (b == CH_BSLASH)
                        mode_next = MODE_WORD_ESC;
                    else
                    begin
                        pre_emit     = 1'b1;
                        pre_res.ev   = EV_WBYTE;
                        pre_res.data = b;
                    end
                end
                MODE_WORD_ESC:
                begin
                    pre_emit     = 1'b1;
                    pre_res.ev   = EV_WBYTE;
                    pre_res.data = b;
                    mode_next    = MODE_WORD;
                end
                MODE_BRACE, MODE_QSTR:
                begin
                    if (mode_reg == MODE_BRACE && b == CH_BAR)
                    begin
                        count_next = '0;
                        mode_next  = MODE_DIGITS;
                    end
                    else if (b == CH_RBRACE)
                    begin
                        pre_emit   = 1'b1;
                        pre_res.ev = EV_SEND;
                        mode_next  = MODE_IDLE;
                    end
                    else if (b == CH_BSLASH)
                        mode_next = MODE_QSTR_ESC;
                    else
                    begin
                        pre_emit     = 1'b1;
                        pre_res.ev   = EV_SBYTE;
                        pre_res.data = b;
                        mode_next    = MODE_QSTR;
                    end
                end
                MODE_QSTR_ESC:
                begin
                    pre_emit     = 1'b1;
                    pre_res.ev   = EV_SBYTE;
                    pre_res.data = b;
                    mode_next    = MODE_QSTR;
                end
                MODE_DIGITS, MODE_COUNTED:
                begin
                    if (mode_reg == MODE_DIGITS && b >= CH_ZERO && b <= CH_NINE)
                        count_next = digit_count;
                    else if (mode_reg == MODE_DIGITS && b == CH_BAR)
                        mode_next = (count_reg == '0) ? MODE_CLOSE : MODE_COUNTED;
                    else if (mode_reg == MODE_COUNTED || count_reg != '0)
                    begin
                        // counted content byte; a missing bar is flagged on it
                        pre_emit     = 1'b1;
                        pre_res.ev   = EV_SBYTE;
                        pre_res.data = b;
                        pre_res.err  = (mode_reg == MODE_DIGITS) ? ERR_NO_BAR : ERR_NONE;
                        if (count_reg != '0)
                            count_next = count_reg - 1'b1;
                        mode_next = (count_reg <= COUNT_BITS'(1)) ? MODE_CLOSE : MODE_COUNTED;
                    end
                    else
                    begin
                        pre_emit    = 1'b1;
                        pre_res.ev  = EV_SEND;
                        pre_res.err = ERR_NO_BAR;
                        if (b == CH_RBRACE)
                            mode_next = MODE_IDLE;
                        else
                            do_idle = 1'b1;
                    end
                end
                MODE_CLOSE:
                begin
                    pre_emit   = 1'b1;
                    pre_res.ev = EV_SEND;
                    if (b == CH_RBRACE)
                        mode_next = MODE_IDLE;
                    else
                    begin
                        pre_res.err = ERR_NO_CLOSE;
                        do_idle     = 1'b1;
                    end
                end
                default:
                    do_idle = 1'b1;
            endcase

            // handling between tokens
            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                if (is_ws(b))
                begin
                    if (b == CH_LF && line_reg != {LINE_BITS{1'b1}})
                        line_next = line_reg + 1'b1;
                end
                else
                begin
                    start_next = line_reg;
                    unique case (b)
                        CH_QUOTE:  mode_next = MODE_QUOTE;
                        CH_LPAREN:
                        begin
                            idle_emit   = 1'b1;
                            idle_res.ev = EV_OPEN;
                        end
                        CH_RPAREN:
                        begin
                            idle_emit   = 1'b1;
                            idle_res.ev = EV_CLOSE;
                        end
                        CH_LBRACE: mode_next = MODE_BRACE;
                        CH_RBRACE:
                        begin
                            idle_emit    = 1'b1;
                            idle_res.ev  = EV_WEND;
                            idle_res.err = ERR_STRAY_CLOSE;
                        end
                        CH_BSLASH: mode_next = MODE_WORD_ESC;
                        default:
                        begin
                            idle_emit     = 1'b1;
                            idle_res.ev   = EV_WBYTE;
                            idle_res.data = b;
                            mode_next     = MODE_WORD;
                        end
                    endcase
                end
            end
        end
    end

    assign push_valid   = accept && (pre_emit || idle_emit);
    assign push_data.r0 = pre_emit ? pre_res : idle_res;
    assign push_data.r1 = idle_res;
    assign push_data.two = pre_emit && idle_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= LINE_BITS'(1);
            start_reg <= LINE_BITS'(1);
            count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    // counted bytes still owed whenever content is being counted
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_COUNTED |-> count_reg != '0)
        else $error("counted string with no bytes left");

    // end of stream returns the lexer to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.command |=> mode_reg == MODE_IDLE && line_reg == LINE_BITS'(1)
                                   && start_reg == LINE_BITS'(1) && count_reg == '0)
        else $error("lexer not restarted after end of stream");

endmodule

FILE: src/stok_queue.sv
// short event-packet queue between lexer front end and output stage
// depends on stok_pkg
module stok_queue #(
    parameter int DEPTH = stok_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  stok_pkg::pkt_t push_data,
    output logic           push_ready,
    output logic           pop_valid,
    output stok_pkg::pkt_t pop_data,
    input  logic           pop_ready
);
    import stok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_data;
    end

    // the front end stalls its input when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("event packet pushed into full queue");

endmodule

FILE: src/stok_back.sv
// output stage: unpacks event packets into single events, one per cycle while the consumer is ready
// depends on stok_pkg and stok_if
module stok_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  stok_pkg::pkt_t pop_data,
    output logic           pop_ready,
    stok_out_if.source     events
);
    import stok_pkg::*;

    logic ovalid_reg, ovalid_next;
    logic sel_reg, sel_next;
    res_t ores_reg;
    logic olast_reg;
    logic load, take;

    // output register free, or being emptied this cycle
    assign load      = !ovalid_reg || events.ready;
    assign take      = load && pop_valid;
    // packet leaves the queue once its last event is loaded
    assign pop_ready = load && (sel_reg || !pop_data.two);

    always_comb
    begin
        ovalid_next = ovalid_reg;
        sel_next    = sel_reg;
        if (load)
            ovalid_next = pop_valid;
        if (take)
            sel_next = sel_reg ? 1'b0 : pop_data.two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ores_reg  <= sel_reg ? pop_data.r1 : pop_data.r0;
            olast_reg <= sel_reg || !pop_data.two;
        end
    end

    assign events.valid      = ovalid_reg;
    assign events.event_res  = ores_reg.ev;
    assign events.out_byte   = ores_reg.data;
    assign events.token_line = ores_reg.line;
    assign events.error_code = ores_reg.err;
    assign events.last       = olast_reg;

    // second event pending means its packet still sits at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> pop_valid && pop_data.two)
        else $error("second event pending without a two-event packet");

endmodule

FILE: src/s_expression_tokenizer.sv
// s-expression tokenizer top level: lexer front end, packet queue, output stage
// depends on stok_pkg, stok_if, stok_front, stok_queue and stok_back
//
// Takes one text byte per word on "text" (command 0 = byte, 1 = end of
// stream) and gives token events on "events": open, quote-open, close, word
// bytes closed by a word end, and string bytes closed by a string end, each
// with the line where its token began and an error code. A byte causes zero,
// one or two events; the last event of a byte has "last" set. Brace strings
// run to the next close brace, counted strings {|n|...} carry n raw bytes,
// a backslash makes the next byte literal, and only newlines between tokens
// count lines. End of stream closes any open token and restarts line
// counting at one. A byte is taken every cycle while the four-entry packet
// queue has room; the single output register sends one event per cycle
// while the consumer is ready, so a byte that causes two events holds the
// queue head for both, and a steady run of them fills the queue and stalls
// the input. An event passes through the queue slot, then the output register.
module s_expression_tokenizer #(
    parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
    parameter int COUNT_BITS  = stok_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = stok_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    stok_in_if.sink    text,
    stok_out_if.source events
);
    import stok_pkg::*;

    // front end to queue
    logic push_valid, push_ready;
    pkt_t push_data;
    // queue to output stage
    logic pop_valid, pop_ready;
    pkt_t pop_data;

    // lexer state, one byte per cycle while the queue has room
    stok_front #(
        .LINE_BITS  (LINE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // decouples lexer stalls from output back-pressure
    stok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // one event per cycle to the consumer while it is ready
    stok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .events    (events)
    );

endmodule
